// ===== hdl/pmct_pkg.sv =====
// Shared types and constants for the PS/2 mouse cursor tracker.
// No dependencies; imported by every module of the block.
package pmct_pkg;

  typedef logic [11:0] coord_t;  // clamped cursor coordinate
  typedef logic [9:0]  delta_t;  // scaled movement magnitude
  typedef logic [12:0] size_t;   // screen size in pixels

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_GRAPHICS_MODE = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_MOVE_INTERVAL = 8'd3;

  localparam size_t      RST_SCREEN_WIDTH  = 13'd640;
  localparam size_t      RST_SCREEN_HEIGHT = 13'd480;
  localparam logic       RST_GRAPHICS_MODE = 1'b1;
  localparam logic [7:0] RST_MOVE_INTERVAL = 8'd10;

  localparam coord_t RST_POS_X = coord_t'(RST_SCREEN_WIDTH >> 1);
  localparam coord_t RST_POS_Y = coord_t'(RST_SCREEN_HEIGHT >> 1);

  localparam size_t  CURSOR_MARGIN = 13'd16;
  localparam coord_t LIMIT_MAX     = 12'd4080;
  localparam coord_t EVENT_DX      = 12'd3;
  localparam coord_t EVENT_DY      = 12'd1;

  localparam int unsigned STATUS_LEFT  = 0;
  localparam int unsigned STATUS_XSIGN = 4;
  localparam int unsigned STATUS_YSIGN = 5;

  localparam logic EVT_CLICK = 1'b0;
  localparam logic EVT_MOVE  = 1'b1;

endpackage

// ===== hdl/ps2_mouse_cursor_tracker.sv =====
// Top level of the PS/2 mouse cursor tracker: config registers, cursor and
// button state, result register. Depends on pmct_pkg and pmct_axis.
//
// Takes one assembled three-byte PS/2 packet per transfer and returns one
// result per packet. A packet can be accepted on every clock cycle; its
// result appears in the output register on the cycle after acceptance and
// the input keeps accepting while that result waits, as long as the
// downstream side takes it in the same cycle. The whole cursor and button
// update is combinational logic between the packet input and the state and
// result registers. Configuration writes are taken every cycle and should
// only be issued while no packet is in flight.
module ps2_mouse_cursor_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // packet input
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [23:0]                    s_tdata_i,  // status_byte, x_byte, y_byte
  // result output
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [47:0]                    m_tdata_o,  // cursor_x, cursor_y, event_x, event_y
  output logic [1:0]                     m_tuser_o,  // event_valid, event_kind
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pmct_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pmct_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pmct_pkg::*;

  size_t      screen_width_q, screen_height_q;
  logic       graphics_mode_q;
  logic [7:0] move_interval_q;

  coord_t     pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic       held_q, held_d;
  logic [7:0] count_q, count_d, count_inc;

  logic       out_valid_q;
  coord_t     cur_x_q, cur_y_q, evt_x_q, evt_y_q;
  logic       evt_valid_q, evt_kind_q;
  logic       evt_valid_d, evt_kind_d;

  logic [7:0] status_b, x_b, y_b, x_mag, y_mag;
  logic       x_neg, y_neg, left;
  delta_t     x_del, y_del;
  logic       accept;

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = !out_valid_q || m_tready_i;
  assign accept      = s_tvalid_i && s_tready_o;

  assign status_b = s_tdata_i[7:0];
  assign x_b      = s_tdata_i[15:8];
  assign y_b      = s_tdata_i[23:16];
  assign left     = status_b[STATUS_LEFT];
  assign x_neg    = status_b[STATUS_XSIGN];
  assign y_neg    = status_b[STATUS_YSIGN];
  assign x_mag    = x_neg ? 8'(-x_b) : x_b;
  assign y_mag    = y_neg ? 8'(-y_b) : y_b;
  assign x_del    = {x_mag, 2'b00};
  assign y_del    = {2'b00, y_mag} + {1'b0, y_mag, 1'b0};

  pmct_axis u_axis_x (
    .pos_i   (pos_x_q),
    .delta_i (x_del),
    .sub_i   (x_neg),
    .size_i  (screen_width_q),
    .pos_o   (pos_x_d)
  );

  // screen y grows downward, so a positive mouse y moves the cursor up
  pmct_axis u_axis_y (
    .pos_i   (pos_y_q),
    .delta_i (y_del),
    .sub_i   (!y_neg),
    .size_i  (screen_height_q),
    .pos_o   (pos_y_d)
  );

  assign count_inc = count_q + 8'd1;

  always_comb begin
    held_d      = held_q;
    count_d     = count_q;
    evt_valid_d = 1'b0;
    evt_kind_d  = EVT_CLICK;
    if (graphics_mode_q) begin
      if (left) begin
        if (!held_q) begin
          held_d      = 1'b1;
          count_d     = '0;
          evt_valid_d = 1'b1;
        end else if (count_inc > move_interval_q) begin
          count_d     = '0;
          evt_valid_d = 1'b1;
          evt_kind_d  = EVT_MOVE;
        end else begin
          count_d = count_inc;
        end
      end else begin
        held_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= RST_SCREEN_WIDTH;
      screen_height_q <= RST_SCREEN_HEIGHT;
      graphics_mode_q <= RST_GRAPHICS_MODE;
      move_interval_q <= RST_MOVE_INTERVAL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        CFG_GRAPHICS_MODE: graphics_mode_q <= cfg_data_i[0];
        CFG_MOVE_INTERVAL: move_interval_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= RST_POS_X;
      pos_y_q     <= RST_POS_Y;
      held_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      evt_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_x_q     <= pos_x_d;
        pos_y_q     <= pos_y_d;
        held_q      <= held_d;
        count_q     <= count_d;
        evt_valid_q <= evt_valid_d;
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, event fields zero when there is no event
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_x_q    <= pos_x_d;
      cur_y_q    <= pos_y_d;
      evt_kind_q <= evt_valid_d ? evt_kind_d : 1'b0;
      evt_x_q    <= evt_valid_d ? pos_x_d + EVENT_DX : '0;
      evt_y_q    <= evt_valid_d ? pos_y_d + EVENT_DY : '0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {evt_y_q, evt_x_q, cur_y_q, cur_x_q};
  assign m_tuser_o  = {evt_kind_q, evt_valid_q};

endmodule

// ===== hdl/pmct_axis.sv =====
// One cursor axis: applies a scaled move, folds underflow to 1 and clamps
// to the screen limit. Depends on pmct_pkg.
module pmct_axis (
  input  pmct_pkg::coord_t pos_i,
  input  pmct_pkg::delta_t delta_i,
  input  logic             sub_i,
  input  pmct_pkg::size_t  size_i,
  output pmct_pkg::coord_t pos_o
);
  import pmct_pkg::*;

  logic [13:0] sum;
  size_t       lim_raw;
  coord_t      lim;
  logic [12:0] val;

  always_comb begin
    if (sub_i) begin
      sum = {2'b00, pos_i} - {4'b0000, delta_i};
    end else begin
      sum = {2'b00, pos_i} + {4'b0000, delta_i};
    end

    lim_raw = (size_i >= CURSOR_MARGIN) ? size_i - CURSOR_MARGIN : '0;
    lim = (lim_raw > {1'b0, LIMIT_MAX}) ? LIMIT_MAX : lim_raw[11:0];

    // negative result is the 14-bit underflow case
    val = sum[13] ? 13'd1 : sum[12:0];
    pos_o = (val > {1'b0, lim}) ? lim : val[11:0];
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for ps2_mouse_cursor_tracker: directed and random
// packet streams against an in-bench cursor/button tracker.
// Depends on pmct_pkg and the block's RTL only.
module tb_top;
  import pmct_pkg::*;

  localparam int unsigned X_GAIN         = 4;
  localparam int unsigned Y_GAIN         = 3;
  localparam int unsigned DRAIN_PAD      = 4;
  localparam int unsigned END_PAD        = 8;
  localparam int unsigned STALL_CYCLES   = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_IDX = 8'd200;

  typedef struct packed {
    logic [11:0] cur_x;
    logic [11:0] cur_y;
    logic        ev_valid;
    logic        ev_kind;
    logic [11:0] ev_x;
    logic [11:0] ev_y;
  } cursor_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_tvalid_i;
  logic                s_tready_o;
  logic [23:0]         s_tdata_i;   // status_byte, x_byte, y_byte
  logic                m_tvalid_o;
  logic                m_tready_i;
  logic [47:0]         m_tdata_o;   // cursor_x, cursor_y, event_x, event_y
  logic [1:0]          m_tuser_o;   // event_valid, event_kind
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ps2_mouse_cursor_tracker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // tracker state and register copy
  logic [12:0] trk_pos_x;
  logic [12:0] trk_pos_y;
  logic        trk_held;
  logic [7:0]  trk_held_cnt;
  size_t       cfg_width;
  size_t       cfg_height;
  logic        cfg_gfx;
  logic [7:0]  cfg_interval;

  cursor_result_t pending_cursor_q[$];
  int unsigned    error_count;
  int unsigned    packets_sent;
  int unsigned    send_idle_pct;
  int unsigned    rcv_idle_pct;
  logic           stall_req;
  int unsigned    stall_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [12:0] step_axis(logic [12:0] pos, logic [7:0] mag,
                                            int unsigned gain, logic backward,
                                            size_t size);
    logic [15:0] delta;
    logic [15:0] moved;
    size_t       lim;
    delta = 16'(mag * gain);
    moved = backward ? 16'(pos) - delta : 16'(pos) + delta;
    lim = (size >= CURSOR_MARGIN) ? size - CURSOR_MARGIN : '0;
    if (lim > 13'(LIMIT_MAX)) lim = 13'(LIMIT_MAX);
    // wrap below zero shows up as bit 15
    if (moved[15]) moved = 16'd1;
    if (moved > 16'(lim)) moved = 16'(lim);
    return moved[12:0];
  endfunction

  function automatic cursor_result_t track_packet(logic [7:0] st, logic [7:0] xb,
                                                  logic [7:0] yb);
    cursor_result_t r;
    logic           xneg;
    logic           yneg;
    logic [7:0]     xm;
    logic [7:0]     ym;
    logic [12:0]    nx;
    logic [12:0]    ny;
    xneg = st[STATUS_XSIGN];
    yneg = st[STATUS_YSIGN];
    xm = xneg ? (~xb + 8'd1) : xb;
    ym = yneg ? (~yb + 8'd1) : yb;
    nx = step_axis(trk_pos_x, xm, X_GAIN, xneg, cfg_width);
    // screen y grows downward
    ny = step_axis(trk_pos_y, ym, Y_GAIN, !yneg, cfg_height);
    r = '0;
    if (cfg_gfx) begin
      if (st[STATUS_LEFT]) begin
        if (!trk_held) begin
          trk_held_cnt = 8'd0;
          r.ev_valid = 1'b1;
          r.ev_kind = EVT_CLICK;
          trk_held = 1'b1;
        end else begin
          trk_held_cnt = trk_held_cnt + 8'd1;
          if (trk_held_cnt > cfg_interval) begin
            trk_held_cnt = 8'd0;
            r.ev_valid = 1'b1;
            r.ev_kind = EVT_MOVE;
          end
        end
      end else begin
        trk_held = 1'b0;
      end
    end
    trk_pos_x = nx;
    trk_pos_y = ny;
    r.cur_x = nx[11:0];
    r.cur_y = ny[11:0];
    if (r.ev_valid) begin
      r.ev_x = 12'(nx + 13'(EVENT_DX));
      r.ev_y = 12'(ny + 13'(EVENT_DY));
    end
    return r;
  endfunction

  // caller sits at a rising edge; valid stays up after the transfer
  task automatic send_packet(input logic [7:0] st, input logic [7:0] xb,
                             input logic [7:0] yb);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      s_tdata_i <= 24'($urandom);
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= {yb, xb, st};
    @(negedge clk_i);
    while (!s_tready_o) @(negedge clk_i);
    @(posedge clk_i);
    pending_cursor_q.push_back(track_packet(st, xb, yb));
    packets_sent++;
  endtask

  task automatic send_move(input logic left);
    logic [7:0] st;
    logic [7:0] xm;
    logic [7:0] ym;
    logic       xs;
    logic       ys;
    xs = 1'($urandom_range(1));
    ys = 1'($urandom_range(1));
    xm = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
    ym = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
    st = 8'($urandom);
    st[STATUS_LEFT] = left;
    st[STATUS_XSIGN] = xs;
    st[STATUS_YSIGN] = ys;
    send_packet(st, xs ? (~xm + 8'd1) : xm, ys ? (~ym + 8'd1) : ym);
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    while (pending_cursor_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    case (idx)
      CFG_SCREEN_WIDTH:  cfg_width = data;
      CFG_SCREEN_HEIGHT: cfg_height = data;
      CFG_GRAPHICS_MODE: cfg_gfx = data[0];
      CFG_MOVE_INTERVAL: cfg_interval = data[7:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input size_t w, input size_t h, input logic gfx,
                            input logic [7:0] iv);
    wait_drained();
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    // unused upper data bits must not matter
    write_reg(CFG_GRAPHICS_MODE, {12'($urandom), gfx});
    write_reg(CFG_MOVE_INTERVAL, {5'($urandom), iv});
  endtask

  function automatic size_t pick_size();
    return ($urandom_range(3) == 0) ? size_t'($urandom_range(20)) : size_t'($urandom);
  endfunction

  // mostly press/hold/release runs, some fully random packets
  task automatic run_packet_mix(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned run_len;
    int unsigned k;
    stop_at = packets_sent + n_items;
    while (packets_sent < stop_at) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(2) == 0) run_len = $urandom_range(cfg_interval + 3, 1);
        else run_len = $urandom_range(6, 1);
        if (run_len > stop_at - packets_sent) run_len = stop_at - packets_sent;
        for (k = 0; k < run_len; k++) send_move(1'b1);
        repeat ($urandom_range(2, 1)) send_move(1'b0);
      end else begin
        send_packet(8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // reset registers: zero move, click, extreme moves while held, move event, release
  task automatic test_reset_directed();
    logic [23:0] pkts [14];
    int          i;
    pkts = '{24'h00_00_00, 24'h01_00_00, 24'h01_7F_7F, 24'h31_80_80, 24'h31_00_00,
             24'hC1_FF_FF, 24'h31_01_01, 24'h0F_10_20, 24'h11_81_05, 24'h21_05_FB,
             24'h01_00_00, 24'h01_00_00, 24'h01_03_03, 24'h00_FF_00};
    for (i = 0; i < 14; i++) send_packet(pkts[i][23:16], pkts[i][15:8], pkts[i][7:0]);
  endtask

  // tiny and huge screens, ignored register index, text mode, zero interval
  task automatic test_config_cases();
    int i;
    wait_drained();
    write_reg(CFG_SCREEN_WIDTH, 13'd8);
    write_reg(CFG_SCREEN_HEIGHT, 13'd15);
    write_reg(CFG_SPARE_IDX, 13'h1FFF);
    send_packet(8'h00, 8'h01, 8'h00);
    set_config(13'h1FFF, 13'h1FFF, 1'b0, 8'd10);
    for (i = 0; i < 5; i++) send_packet(8'h21, 8'hFF, 8'h01);
    set_config(13'h1FFF, 13'h1FFF, 1'b1, 8'd0);
    for (i = 0; i < 3; i++) send_packet(8'h01, 8'h00, 8'h00);
  endtask

  task automatic test_random_mix(input int unsigned chunks);
    int unsigned c;
    for (c = 0; c < chunks; c++) begin
      case (c % 4)
        0: set_config(13'd32, 13'd32, 1'b1, 8'd0);
        1: set_config(13'd4096, 13'd4096, 1'b1, $urandom_range(1) ? 8'd255 : 8'd254);
        2: begin
          set_config(pick_size(), pick_size(), 1'($urandom_range(1)),
                     8'($urandom_range(255)));
          write_reg(CfgIdxW'($urandom_range(255, 4)), CfgDataW'($urandom));
        end
        default: set_config(size_t'($urandom_range(4096, 32)), size_t'($urandom_range(4096, 32)),
                            1'b1, 8'($urandom_range(20)));
      endcase
      run_packet_mix(140);
    end
  endtask

  // downstream holds off while packets keep coming, so the input backs up
  task automatic test_output_stall();
    set_config(RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, 1'b1, 8'd3);
    stall_req = 1'b1;
    run_packet_mix(60);
  endtask

  always @(posedge clk_i) begin
    if (stall_req) begin
      stall_left = STALL_CYCLES;
      stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // inputs only change at rising edges, so a negedge sample predicts the transfer
  always @(negedge clk_i) begin : result_check
    cursor_result_t got;
    cursor_result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got.cur_x = m_tdata_o[11:0];
      got.cur_y = m_tdata_o[23:12];
      got.ev_x = m_tdata_o[35:24];
      got.ev_y = m_tdata_o[47:36];
      got.ev_valid = m_tuser_o[0];
      got.ev_kind = m_tuser_o[1];
      if (pending_cursor_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("tb_top: unexpected result x=%0d y=%0d", got.cur_x, got.cur_y);
      end else begin
        want = pending_cursor_q.pop_front();
        if (got.cur_x !== want.cur_x || got.cur_y !== want.cur_y ||
            got.ev_valid !== want.ev_valid || got.ev_kind !== want.ev_kind ||
            got.ev_x !== want.ev_x || got.ev_y !== want.ev_y) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("tb_top: mismatch exp x=%0d y=%0d ev=%0b kind=%0b ex=%0d ey=%0d",
                     want.cur_x, want.cur_y, want.ev_valid, want.ev_kind, want.ev_x,
                     want.ev_y, " | got x=%0d y=%0d ev=%0b kind=%0b ex=%0d ey=%0d",
                     got.cur_x, got.cur_y, got.ev_valid, got.ev_kind,
                     got.ev_x, got.ev_y);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i = '0;
    m_tready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    stall_req = 1'b0;
    stall_left = 0;
    error_count = 0;
    packets_sent = 0;
    send_idle_pct = 34;
    rcv_idle_pct = 58;
    cfg_width = RST_SCREEN_WIDTH;
    cfg_height = RST_SCREEN_HEIGHT;
    cfg_gfx = RST_GRAPHICS_MODE;
    cfg_interval = RST_MOVE_INTERVAL;
    trk_pos_x = 13'(RST_POS_X);
    trk_pos_y = 13'(RST_POS_Y);
    trk_held = 1'b0;
    trk_held_cnt = 8'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_directed();
    test_config_cases();
    test_random_mix(4);
    send_idle_pct = 58;
    rcv_idle_pct = 34;
    test_random_mix(4);
    send_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_mix(4);
    test_output_stall();

    wait_drained();
    repeat (END_PAD) @(posedge clk_i);
    if (error_count == 0 && pending_cursor_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pmct_pkg.sv
hdl/pmct_axis.sv
hdl/ps2_mouse_cursor_tracker.sv
verif/tb_top.sv
